// ----- rtl/ptt_pkg.sv -----
// Package for the periodic task timer table.
// Holds the slot entry type and the operation and status codes.
// Used by ptt_mem, ptt_ctrl and periodic_task_timer_table_top.
package ptt_pkg;

    // Operation codes of an incoming request
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_POLL = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_ADDED = 3'd0;
    localparam logic [2:0] ST_ZERO  = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_FIRED = 3'd3;
    localparam logic [2:0] ST_NONE  = 3'd4;

    // One task slot as stored in the table memory
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] start;
        logic [31:0] period;
        logic [15:0] count;
        logic        endless;
    } entry_t;

endpackage

// ----- rtl/ptt_mem.sv -----
// Task slot memory: one write port, one read port, registered read data.
// Depends on ptt_pkg for the entry type.
module ptt_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  ptt_pkg::entry_t       wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output ptt_pkg::entry_t       rd_data
);

    ptt_pkg::entry_t mem [DEPTH];

    // Write one slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one slot, data valid the next cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/ptt_ctrl.sv -----
// Control for the task table: request handshake, add, poll scan with
// in-place compaction, tail copy, and the output register.
// Depends on ptt_pkg; drives the ports of ptt_mem.
module ptt_ctrl #(
    parameter int CAPACITY = 64,
    parameter int AW       = 6,
    parameter int CW       = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              operation,
    input  logic [31:0]       now_ms,
    input  logic [15:0]       task_id,
    input  logic [31:0]       start_time,
    input  logic [31:0]       period_ms,
    input  logic [15:0]       repeat_count,
    input  logic              endless,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [15:0]       fired_id,
    output logic              mem_wr_en,
    output logic [AW-1:0]     mem_wr_addr,
    output ptt_pkg::entry_t   mem_wr_data,
    output logic              mem_rd_en,
    output logic [AW-1:0]     mem_rd_addr,
    input  ptt_pkg::entry_t   mem_rd_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_EVAL   = 3'd2;
    localparam logic [2:0] S_CREAD  = 3'd3;
    localparam logic [2:0] S_CWRITE = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]      state_reg, state_next;
    logic [CW-1:0]   used_reg, used_next;
    logic [CW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   wr_reg, wr_next;
    logic            out_valid_reg, out_valid_next;
    logic [31:0]     now_reg, now_next;
    logic [2:0]      res_status_reg, res_status_next;
    logic [15:0]     res_id_reg, res_id_next;
    logic [2:0]      out_status_reg, out_status_next;
    logic [15:0]     out_id_reg, out_id_next;

    logic            accept;
    logic [31:0]     elapsed;
    logic            due;
    logic            spent;
    logic [CW-1:0]   rd_inc;
    logic [CW-1:0]   wr_inc;
    ptt_pkg::entry_t fired_entry;
    ptt_pkg::entry_t add_entry;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign fired_id  = out_id_reg;

    // Evaluate the slot that came back from memory
    assign elapsed = now_reg - mem_rd_data.start;
    assign due     = (elapsed > mem_rd_data.period);
    assign spent   = !mem_rd_data.endless && (mem_rd_data.count == 16'd0);
    assign rd_inc  = rd_reg + CW'(1);
    assign wr_inc  = wr_reg + CW'(1);

    // Restart the fired slot and burn one run if it is finite
    always_comb
    begin
        fired_entry       = mem_rd_data;
        fired_entry.start = now_reg;
        if (!mem_rd_data.endless)
        begin
            fired_entry.count = mem_rd_data.count - 16'd1;
        end
    end

    always_comb
    begin
        add_entry.id      = task_id;
        add_entry.start   = start_time;
        add_entry.period  = period_ms;
        add_entry.count   = repeat_count;
        add_entry.endless = endless;
    end

    // Sequencer: add, scan with compaction, tail copy
    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        now_next        = now_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = wr_reg[AW-1:0];
        mem_wr_data     = mem_rd_data;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = rd_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    now_next    = now_ms;
                    res_id_next = 16'd0;
                    rd_next     = '0;
                    wr_next     = '0;
                    state_next  = S_DONE;
                    if (operation == ptt_pkg::OP_ADD)
                    begin
                        if (!endless && (repeat_count == 16'd0))
                        begin
                            res_status_next = ptt_pkg::ST_ZERO;
                        end
                        else if (used_reg == CW'(CAPACITY))
                        begin
                            res_status_next = ptt_pkg::ST_FULL;
                        end
                        else
                        begin
                            // Append at the end of the list
                            mem_wr_en       = 1'b1;
                            mem_wr_addr     = used_reg[AW-1:0];
                            mem_wr_data     = add_entry;
                            used_next       = used_reg + CW'(1);
                            res_status_next = ptt_pkg::ST_ADDED;
                        end
                    end
                    else
                    begin
                        res_status_next = ptt_pkg::ST_NONE;
                        if (used_reg != '0)
                        begin
                            state_next = S_READ;
                        end
                    end
                end
            end

            S_READ:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                rd_next = rd_inc;
                if (!due)
                begin
                    // Keep the slot, close any gap left by removals
                    mem_wr_en  = (wr_reg != rd_reg);
                    wr_next    = wr_inc;
                    state_next = S_READ;
                    if (rd_inc == used_reg)
                    begin
                        used_next  = wr_inc;
                        state_next = S_DONE;
                    end
                end
                else if (spent)
                begin
                    // Drop the exhausted slot and go on scanning
                    state_next = S_READ;
                    if (rd_inc == used_reg)
                    begin
                        used_next  = wr_reg;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    // Fire this slot, then move the tail down if needed
                    mem_wr_en       = 1'b1;
                    mem_wr_data     = fired_entry;
                    wr_next         = wr_inc;
                    res_status_next = ptt_pkg::ST_FIRED;
                    res_id_next     = mem_rd_data.id;
                    state_next      = S_CREAD;
                    if (rd_inc == used_reg)
                    begin
                        used_next  = wr_inc;
                        state_next = S_DONE;
                    end
                    else if (wr_reg == rd_reg)
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_CREAD:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_CWRITE;
            end

            S_CWRITE:
            begin
                mem_wr_en  = 1'b1;
                wr_next    = wr_inc;
                rd_next    = rd_inc;
                state_next = S_CREAD;
                if (rd_inc == used_reg)
                begin
                    used_next  = wr_inc;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: load a finished result, drop it once taken
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_DONE) && (!out_valid_reg || out_ready))
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_id_next     = res_id_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        now_reg        <= now_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
    end

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(CAPACITY))
        else $error("slot count above capacity");

    a_scan_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ || state_reg == S_EVAL || state_reg == S_CREAD
         || state_reg == S_CWRITE) |-> (wr_reg <= rd_reg && rd_reg < used_reg))
        else $error("scan pointers out of order");

    a_used_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !in_valid) |=> $stable(used_reg))
        else $error("slot count changed with no request");

    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ptt_pkg::ST_FIRED) |-> out_id_reg == 16'd0)
        else $error("id set on a result that did not fire");
`endif

endmodule

// ----- rtl/periodic_task_timer_table_top.sv -----
// Top level of the periodic task timer table.
// Depends on ptt_pkg, ptt_mem and ptt_ctrl.
//
// Usage:
//   Input channel in_valid/in_ready carries one request: operation selects
//   add (append a task) or poll (find the first due task at now_ms).
//   Output channel out_valid/out_ready returns one result per request:
//   status and fired_id.
//   Timing: a request is taken only while the controller is idle.
//   An add goes straight to the done state, then to the output register.
//   A poll reads and checks one slot at a time (one memory read port,
//   registered read data), then copies any tail left by removed slots
//   down one slot at a time.
//   Reset: the list is empty and no result is pending; the slot memory
//   is not cleared, slots are only read below the fill count.
//   Stall: a finished result waits in the output register; the next
//   request is accepted meanwhile and its result holds until the output
//   register frees up.
module periodic_task_timer_table_top #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [31:0] now_ms,
    input  logic [15:0] task_id,
    input  logic [31:0] start_time,
    input  logic [31:0] period_ms,
    input  logic [15:0] repeat_count,
    input  logic        endless,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] fired_id
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic            mem_wr_en;
    logic [AW-1:0]   mem_wr_addr;
    ptt_pkg::entry_t mem_wr_data;
    logic            mem_rd_en;
    logic [AW-1:0]   mem_rd_addr;
    ptt_pkg::entry_t mem_rd_data;

    // Slot storage
    ptt_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Request sequencing and result output
    ptt_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .now_ms       (now_ms),
        .task_id      (task_id),
        .start_time   (start_time),
        .period_ms    (period_ms),
        .repeat_count (repeat_count),
        .endless      (endless),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .fired_id     (fired_id),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data)
    );

endmodule

// ----- sim/tb_periodic_task_timer_table_top.sv -----
// Testbench for periodic_task_timer_table_top: directed table, then random add/poll requests.
// Checks each result against an in-bench copy of the task list, or against a hand-written outcome for fixed rows.
// Depends on ptt_pkg and the RTL under rtl/.
module tb_periodic_task_timer_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 1850;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic        op;
        logic [31:0] now;
        logic [15:0] id;
        logic [31:0] start;
        logic [31:0] period;
        logic [15:0] count;
        logic        endless;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] fired_id;
    } outcome_t;

    // One row of the directed table; fixed marks a hand-written outcome
    typedef struct packed {
        request_t    rq;
        logic [7:0]  reps;
        logic        fixed;
        logic [2:0]  want_status;
        logic [15:0] want_id;
    } plan_row_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic        operation    = ptt_pkg::OP_ADD;
    logic [31:0] now_ms       = '0;
    logic [15:0] task_id      = '0;
    logic [31:0] start_time   = '0;
    logic [31:0] period_ms    = '0;
    logic [15:0] repeat_count = '0;
    logic        endless      = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [2:0]  status;
    logic [15:0] fired_id;

    // In-bench copy of the task list
    ptt_pkg::entry_t task_slots [CAPACITY];
    int unsigned     task_fill = 0;

    outcome_t    owed_outcomes [$];
    int          mismatches     = 0;
    int          requests_taken = 0;
    bit          quiet          = 1'b0;
    bit          pressure_done  = 1'b0;
    int          hold_left      = 0;

    plan_row_t   plan [20];

    periodic_task_timer_table_top #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .now_ms      (now_ms),
        .task_id     (task_id),
        .start_time  (start_time),
        .period_ms   (period_ms),
        .repeat_count(repeat_count),
        .endless     (endless),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .fired_id    (fired_id)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("tb_periodic_task_timer_table_top NOT OK");
        $finish;
    end

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        if (mismatches <= 50)
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    // Apply one request to the task list and return its outcome
    function automatic outcome_t table_apply(input request_t rq);
        outcome_t    res;
        int unsigned pos;
        int unsigned k;
        logic [31:0] elapsed;
        res.status   = ptt_pkg::ST_NONE;
        res.fired_id = '0;
        if (rq.op == ptt_pkg::OP_ADD)
        begin
            if (!rq.endless && rq.count == 16'h0)
                res.status = ptt_pkg::ST_ZERO;
            else if (task_fill >= CAPACITY)
                res.status = ptt_pkg::ST_FULL;
            else
            begin
                task_slots[task_fill].id      = rq.id;
                task_slots[task_fill].start   = rq.start;
                task_slots[task_fill].period  = rq.period;
                task_slots[task_fill].count   = rq.count;
                task_slots[task_fill].endless = rq.endless;
                task_fill++;
                res.status = ptt_pkg::ST_ADDED;
            end
        end
        else
        begin
            pos = 0;
            while (pos < task_fill)
            begin
                elapsed = rq.now - task_slots[pos].start;
                if (elapsed > task_slots[pos].period)
                begin
                    task_slots[pos].start = rq.now;
                    if (!task_slots[pos].endless && task_slots[pos].count == 16'h0)
                    begin
                        // drop the spent task, keep order, rescan this position
                        for (k = pos; k + 1 < task_fill; k++)
                            task_slots[k] = task_slots[k + 1];
                        task_fill--;
                    end
                    else
                    begin
                        if (!task_slots[pos].endless)
                            task_slots[pos].count = task_slots[pos].count - 16'd1;
                        res.status   = ptt_pkg::ST_FIRED;
                        res.fired_id = task_slots[pos].id;
                        break;
                    end
                end
                else
                    pos++;
            end
        end
        return res;
    endfunction

    // Offer one request after an optional gap and hold it until taken
    task offer_request(input request_t rq, input bit fixed, input outcome_t fixed_outcome);
        int       gap;
        outcome_t predicted;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < 30)
            gap = $urandom_range(1, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= rq.op;
        now_ms       <= rq.now;
        task_id      <= rq.id;
        start_time   <= rq.start;
        period_ms    <= rq.period;
        repeat_count <= rq.count;
        endless      <= rq.endless;
        do
            @(posedge clk);
        while (!in_ready);
        requests_taken++;
        predicted = table_apply(rq);
        owed_outcomes.insert(owed_outcomes.size(), fixed ? fixed_outcome : predicted);
    endtask

    // Drive the result side: random stalls, one long hold-off, a quiet stretch
    always @(posedge clk)
    begin
        if (!pressure_done && requests_taken >= 400)
        begin
            pressure_done <= 1'b1;
            hold_left     <= 500;
            out_ready     <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= quiet || ($urandom_range(0, 99) >= 30);
    end

    // Compare each result with the oldest owed outcome
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_outcomes.size() == 0)
                report_mismatch("result with no request outstanding", {13'h0, status, fired_id}, '0);
            else
            begin
                want = owed_outcomes.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (fired_id !== want.fired_id)
                    report_mismatch("fired_id", 32'(fired_id), 32'(want.fired_id));
            end
        end
    end

    initial
    begin
        request_t    rq;
        outcome_t    fixed_outcome;
        logic [31:0] clock_ms;
        int          n;
        int          mode;
        int          span;
        int          add_pct;
        int          pick;
        int          r;
        int          j;

        // Directed table: op, now, id, start, period, count, endless, reps, fixed, status, id
        plan[0]  = '{'{ptt_pkg::OP_POLL, 32'h0, 16'h0, 32'h0, 32'h0, 16'h0, 1'b0},
                     8'd1, 1'b1, ptt_pkg::ST_NONE, 16'h0};
        plan[1]  = '{'{ptt_pkg::OP_ADD, 32'h0, 16'hFFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 16'h0, 1'b0},
                     8'd1, 1'b1, ptt_pkg::ST_ZERO, 16'h0};
        plan[2]  = '{'{ptt_pkg::OP_ADD, 32'h0, 16'h0011, 32'h0, 32'd5, 16'd1, 1'b0},
                     8'd1, 1'b1, ptt_pkg::ST_ADDED, 16'h0};
        plan[3]  = '{'{ptt_pkg::OP_ADD, 32'h0, 16'h0022, 32'h0, 32'd5, 16'd2, 1'b0},
                     8'd1, 1'b1, ptt_pkg::ST_ADDED, 16'h0};
        plan[4]  = '{'{ptt_pkg::OP_POLL, 32'd5, 16'h0, 32'h0, 32'h0, 16'h0, 1'b0},
                     8'd1, 1'b0, ptt_pkg::ST_NONE, 16'h0};
        plan[5]  = '{'{ptt_pkg::OP_POLL, 32'd6, 16'h0, 32'h0, 32'h0, 16'h0, 1'b0},
                     8'd1, 1'b0, ptt_pkg::ST_NONE, 16'h0};
        // spent task dropped, scan goes on to the next one in the same poll
        plan[6]  = '{'{ptt_pkg::OP_POLL, 32'd12, 16'h0, 32'h0, 32'h0, 16'h0, 1'b0},
                     8'd1, 1'b0, ptt_pkg::ST_NONE, 16'h0};
        plan[7]  = '{'{ptt_pkg::OP_POLL, 32'd12, 16'h0, 32'h0, 32'h0, 16'h0, 1'b0},
                     8'd1, 1'b0, ptt_pkg::ST_NONE, 16'h0};
        // endless task is taken even with a zero count
        plan[8]  = '{'{ptt_pkg::OP_ADD, 32'h0, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 16'h0, 1'b1},
                     8'd1, 1'b1, ptt_pkg::ST_ADDED, 16'h0};
        plan[9]  = '{'{ptt_pkg::OP_ADD, 32'hFFFF_FFFF, 16'h0, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 16'hFFFF, 1'b0},
                     8'd1, 1'b1, ptt_pkg::ST_ADDED, 16'h0};
        plan[10] = '{'{ptt_pkg::OP_POLL, 32'hFFFF_FFFF, 16'h0, 32'h0, 32'h0, 16'h0, 1'b0},
                     8'd1, 1'b0, ptt_pkg::ST_NONE, 16'h0};
        plan[11] = '{'{ptt_pkg::OP_POLL, 32'hFFFF_FFFF, 16'h0, 32'h0, 32'h0, 16'h0, 1'b0},
                     8'd1, 1'b0, ptt_pkg::ST_NONE, 16'h0};
        // time wraps through zero
        plan[12] = '{'{ptt_pkg::OP_POLL, 32'h0, 16'h0, 32'h0, 32'h0, 16'h0, 1'b0},
                     8'd1, 1'b0, ptt_pkg::ST_NONE, 16'h0};
        // fill the list to the brim
        plan[13] = '{'{ptt_pkg::OP_ADD, 32'h0, 16'h5A5A, 32'h0, 32'h0, 16'd1, 1'b0},
                     8'd61, 1'b0, ptt_pkg::ST_NONE, 16'h0};
        plan[14] = '{'{ptt_pkg::OP_ADD, 32'hFFFF_FFFF, 16'h1357, 32'h0, 32'd9, 16'd3, 1'b0},
                     8'd1, 1'b1, ptt_pkg::ST_FULL, 16'h0};
        plan[15] = '{'{ptt_pkg::OP_ADD, 32'h0, 16'h2468, 32'h0, 32'd9, 16'd0, 1'b1},
                     8'd1, 1'b1, ptt_pkg::ST_FULL, 16'h0};
        // zero count is rejected ahead of the full check
        plan[16] = '{'{ptt_pkg::OP_ADD, 32'h0, 16'h7777, 32'h0, 32'd9, 16'd0, 1'b0},
                     8'd1, 1'b1, ptt_pkg::ST_ZERO, 16'h0};
        plan[17] = '{'{ptt_pkg::OP_POLL, 32'h10, 16'h0, 32'h0, 32'h0, 16'h0, 1'b0},
                     8'd1, 1'b0, ptt_pkg::ST_NONE, 16'h0};
        plan[18] = '{'{ptt_pkg::OP_POLL, 32'h10, 16'h0, 32'h0, 32'h0, 16'h0, 1'b0},
                     8'd1, 1'b0, ptt_pkg::ST_NONE, 16'h0};
        // add fields on a poll are ignored
        plan[19] = '{'{ptt_pkg::OP_POLL, 32'h20, 16'hFFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 16'hFFFF, 1'b1},
                     8'd1, 1'b0, ptt_pkg::ST_NONE, 16'h0};

        // Hold reset, then release it on a clock edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (r = 0; r < 20; r++)
        begin
            fixed_outcome.status   = plan[r].want_status;
            fixed_outcome.fired_id = plan[r].want_id;
            for (j = 0; j < plan[r].reps; j++)
                offer_request(plan[r].rq, plan[r].fixed, fixed_outcome);
        end

        // Random phases: fill-heavy, poll-heavy or mixed, mostly well-formed tasks
        clock_ms = $urandom;
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            mode    = $urandom_range(0, 2);
            span    = $urandom_range(20, 120);
            add_pct = (mode == 0) ? 85 : ((mode == 1) ? 15 : 50);
            if ($urandom_range(0, 9) == 0)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
            for (j = 0; j < span && n < RANDOM_ITEMS; j++)
            begin
                quiet      = (n >= 900 && n < 1150);
                rq.now     = $urandom;
                rq.id      = 16'($urandom);
                rq.start   = $urandom;
                rq.period  = $urandom;
                rq.count   = 16'($urandom);
                rq.endless = 1'($urandom);
                if ($urandom_range(0, 99) < add_pct)
                begin
                    rq.op = ptt_pkg::OP_ADD;
                    if ($urandom_range(0, 9) != 0)
                    begin
                        rq.start   = clock_ms - $urandom_range(0, 8);
                        rq.period  = $urandom_range(0, 40);
                        rq.endless = ($urandom_range(0, 3) == 0);
                        pick       = $urandom_range(0, 19);
                        rq.count   = (pick == 0) ? 16'h0 :
                                     ((pick == 1) ? 16'hFFFF : 16'($urandom_range(1, 3)));
                    end
                end
                else
                begin
                    rq.op = ptt_pkg::OP_POLL;
                    pick  = $urandom_range(0, 99);
                    if (pick < 4)
                        clock_ms = $urandom;
                    else
                        clock_ms = clock_ms + $urandom_range(0, 24);
                    if (pick != 99)
                        rq.now = clock_ms;
                end
                offer_request(rq, 1'b0, '0);
                n++;
            end
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        // Wait out every owed result, then watch for strays
        while (owed_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb_periodic_task_timer_table_top OK");
        else
            $display("tb_periodic_task_timer_table_top NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ptt_pkg.sv
rtl/ptt_mem.sv
rtl/ptt_ctrl.sv
rtl/periodic_task_timer_table_top.sv
sim/tb_periodic_task_timer_table_top.sv
